@@ hdl/mme_pkg.sv @@
package mme_pkg;

    // Largest matrix dimension and the derived index widths.
    localparam int MAX_DIM     = 8;
    localparam int IDX_W       = $clog2(MAX_DIM);
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Fixed field widths of the channels and the configuration port.
    localparam int ACT_W     = 2;
    localparam int ROW_W     = 3;
    localparam int DATA_W    = 32;
    localparam int DIM_W     = 4;
    localparam int CFG_IDX_W = 2;

    // A product is exact Q32.32; the sum of MAX_DIM products needs a few guard bits.
    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;
    localparam int FRAC_W = 16;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(3);

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE_A = 2'd0,
        ACT_WRITE_B = 2'd1,
        ACT_RUN     = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_A = 2'd0,
        CFG_COLS_A = 2'd1,
        CFG_COLS_B = 2'd2
    } cfg_index_t;

    // Jump conditions of the sequencer: when true the step counter loads the
    // target, otherwise it moves on to the following step.
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_NO_RUN,
        COND_K_MORE,
        COND_OUT_BUSY,
        COND_ELEM_MORE
    } cond_t;

    typedef logic [2:0] pc_t;

    localparam pc_t PC_IDLE   = 3'd0;
    localparam pc_t PC_START  = 3'd1;
    localparam pc_t PC_READ   = 3'd2;
    localparam pc_t PC_MUL    = 3'd3;
    localparam pc_t PC_ACC    = 3'd4;
    localparam pc_t PC_WAIT   = 3'd5;
    localparam pc_t PC_EMIT   = 3'd6;
    localparam pc_t PC_RETURN = 3'd7;

    typedef struct packed {
        logic  in_rdy;
        logic  acc_clr;
        logic  mem_rd;
        logic  mul_en;
        logic  acc_en;
        logic  emit;
        cond_t cond;
        pc_t   target;
    } ctrl_word_t;

    // The microprogram.
    function automatic ctrl_word_t ucode_rom(pc_t pc);
        ctrl_word_t cw;
        cw = '{in_rdy: 1'b0, acc_clr: 1'b0, mem_rd: 1'b0, mul_en: 1'b0,
               acc_en: 1'b0, emit: 1'b0, cond: COND_NEXT, target: PC_IDLE};
        case (pc)
            PC_IDLE:
            begin
                cw.in_rdy = 1'b1;
                cw.cond   = COND_NO_RUN;
                cw.target = PC_IDLE;
            end
            PC_START:  cw.acc_clr = 1'b1;
            PC_READ:   cw.mem_rd  = 1'b1;
            PC_MUL:    cw.mul_en  = 1'b1;
            PC_ACC:
            begin
                cw.acc_en = 1'b1;
                cw.cond   = COND_K_MORE;
                cw.target = PC_READ;
            end
            PC_WAIT:
            begin
                cw.cond   = COND_OUT_BUSY;
                cw.target = PC_WAIT;
            end
            PC_EMIT:
            begin
                cw.emit   = 1'b1;
                cw.cond   = COND_ELEM_MORE;
                cw.target = PC_START;
            end
            PC_RETURN:
            begin
                cw.cond   = COND_ALWAYS;
                cw.target = PC_IDLE;
            end
            default:
            begin
                cw.cond   = COND_ALWAYS;
                cw.target = PC_IDLE;
            end
        endcase
        return cw;
    endfunction

    // Highest index used for a dimension register: zero acts as one and
    // anything above MAX_DIM acts as MAX_DIM.
    function automatic logic [IDX_W-1:0] dim_limit(logic [DIM_W-1:0] d);
        logic [IDX_W-1:0] lim;
        if (d == '0)
            lim = '0;
        else if (int'(d) > MAX_DIM)
            lim = IDX_W'(MAX_DIM - 1);
        else
            lim = IDX_W'(d - DIM_W'(1));
        return lim;
    endfunction

endpackage

@@ hdl/mme_in_if.sv @@
interface mme_in_if import mme_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ACT_W-1:0]         action;
    logic [ROW_W-1:0]         row;
    logic [ROW_W-1:0]         col;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, action, row, col, value, input ready);
    modport sink   (input valid, action, row, col, value, output ready);
endinterface

@@ hdl/mme_out_if.sv @@
interface mme_out_if import mme_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ROW_W-1:0]         out_row;
    logic [ROW_W-1:0]         out_col;
    logic signed [DATA_W-1:0] product;
    logic                     last;

    modport source (output valid, out_row, out_col, product, last, input ready);
    modport sink   (input valid, out_row, out_col, product, last, output ready);
endinterface

@@ hdl/matrix_multiply_engine_core.sv @@
// Load items (write A or B element) are taken one per cycle while the sequencer is idle
// and give no result. A run item is taken in the idle step; each element of C then
// passes start, read, multiply and accumulate for every inner index, wait and emit on
// the single shared multiply-accumulate unit, and the input is held until the run ends.
// Reset sets the three dimension registers to 3, the sequencer to its idle step and
// empties the output register; both element stores stay undefined until written.
module matrix_multiply_engine_core import mme_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [DIM_W-1:0]     cfg_wdata,
    mme_in_if.sink               in_ch,
    mme_out_if.source            out_ch
);

    // Dimension registers; user writes them only while the block is idle (unenforced).
    logic [DIM_W-1:0] rows_a_reg;
    logic [DIM_W-1:0] cols_a_reg;
    logic [DIM_W-1:0] cols_b_reg;

    // Sequencer: a step counter addressing the microcode table.
    pc_t        pc_reg;
    pc_t        pc_next;
    ctrl_word_t cw;
    logic       jump;

    // Loop indices: i walks the rows of C, j its columns, k the inner dimension.
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] m_lim, n_lim, p_lim;

    // Element stores and their registered read data.
    logic [DATA_W-1:0]        mem_a [STORE_DEPTH];
    logic [DATA_W-1:0]        mem_b [STORE_DEPTH];
    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        rd_addr_a;
    logic [ADDR_W-1:0]        rd_addr_b;
    logic signed [DATA_W-1:0] a_rd_reg;
    logic signed [DATA_W-1:0] b_rd_reg;

    // Multiply-accumulate datapath.
    logic signed [PROD_W-1:0]        mul_full;
    logic signed [PROD_W-1:0]        prod_reg;
    logic signed [ACC_W-1:0]         acc_reg;
    logic signed [ACC_W-1:0]         acc_rounded;
    logic signed [ACC_W-FRAC_W-1:0]  acc_scaled;
    logic signed [DATA_W-1:0]        sat_result;

    // Output register, which parts the sequencer from the result channel.
    logic                     out_valid_reg;
    logic [ROW_W-1:0]         out_row_reg;
    logic [ROW_W-1:0]         out_col_reg;
    logic signed [DATA_W-1:0] out_product_reg;
    logic                     out_last_reg;

    // Handshake terms.
    logic in_xfer;
    logic run_xfer;
    logic load_xfer;
    logic wr_in_range;
    logic k_more;
    logic elem_more;
    logic out_busy;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg <= DIM_RESET;
            cols_a_reg <= DIM_RESET;
            cols_b_reg <= DIM_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_ROWS_A: rows_a_reg <= cfg_wdata;
                CFG_COLS_A: cols_a_reg <= cfg_wdata;
                CFG_COLS_B: cols_b_reg <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    assign m_lim = dim_limit(rows_a_reg);
    assign n_lim = dim_limit(cols_a_reg);
    assign p_lim = dim_limit(cols_b_reg);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    // The control word of the current step drives every enable below. The
    // input channel is open only in the idle step, so a load is written in the
    // cycle of its transfer and a run starts the multiply program.
    assign cw = ucode_rom(pc_reg);

    assign in_ch.ready = cw.in_rdy;
    assign in_xfer     = in_ch.valid && cw.in_rdy;
    assign run_xfer    = in_xfer && (in_ch.action == ACT_RUN);
    assign load_xfer   = in_xfer
                         && ((in_ch.action == ACT_WRITE_A) || (in_ch.action == ACT_WRITE_B));

    assign k_more    = (k_reg != n_lim);
    assign elem_more = !((i_reg == m_lim) && (j_reg == p_lim));
    // The output register is free when it is empty or being taken right now.
    assign out_busy  = out_valid_reg && !out_ch.ready;

    always_comb
    begin
        case (cw.cond)
            COND_NEXT:      jump = 1'b0;
            COND_ALWAYS:    jump = 1'b1;
            COND_NO_RUN:    jump = !run_xfer;
            COND_K_MORE:    jump = k_more;
            COND_OUT_BUSY:  jump = out_busy;
            COND_ELEM_MORE: jump = elem_more;
            default:        jump = 1'b1;
        endcase
        pc_next = jump ? cw.target : pc_t'(pc_reg + pc_t'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= PC_IDLE;
        else
            pc_reg <= pc_next;
    end

    // ------------------------------------------------------------------
    // Row-major walk over C
    // ------------------------------------------------------------------
    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        if (run_xfer)
        begin
            i_next = '0;
            j_next = '0;
        end
        else if (cw.emit)
        begin
            if (j_reg == p_lim)
            begin
                j_next = '0;
                i_next = IDX_W'(i_reg + IDX_W'(1));
            end
            else
            begin
                j_next = IDX_W'(j_reg + IDX_W'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
        end
        else
        begin
            i_reg <= i_next;
            j_reg <= j_next;
            if (cw.acc_clr)
                k_reg <= '0;
            else if (cw.acc_en)
                k_reg <= IDX_W'(k_reg + IDX_W'(1));
        end
    end

    // ------------------------------------------------------------------
    // Element stores
    // ------------------------------------------------------------------
    // Element (r, c) lives at entry r * MAX_DIM + c. A write whose row or
    // column lies beyond the largest dimension is dropped.
    assign wr_addr     = ADDR_W'(int'(in_ch.row) * MAX_DIM + int'(in_ch.col));
    assign wr_in_range = (int'(in_ch.row) < MAX_DIM) && (int'(in_ch.col) < MAX_DIM);
    assign rd_addr_a   = ADDR_W'(int'(i_reg) * MAX_DIM + int'(k_reg));
    assign rd_addr_b   = ADDR_W'(int'(k_reg) * MAX_DIM + int'(j_reg));

    always_ff @(posedge clk)
    begin
        if (load_xfer && wr_in_range && (in_ch.action == ACT_WRITE_A))
            mem_a[wr_addr] <= in_ch.value;
        if (load_xfer && wr_in_range && (in_ch.action == ACT_WRITE_B))
            mem_b[wr_addr] <= in_ch.value;
    end

    always_ff @(posedge clk)
    begin
        if (cw.mem_rd)
        begin
            a_rd_reg <= mem_a[rd_addr_a];
            b_rd_reg <= mem_b[rd_addr_b];
        end
    end

    // ------------------------------------------------------------------
    // Multiply-accumulate
    // ------------------------------------------------------------------
    // Each product is exact Q32.32 and the sum stays exact in the wide
    // accumulator, so the result is rounded only once.
    assign mul_full = a_rd_reg * b_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cw.mul_en)
            prod_reg <= mul_full;
        if (cw.acc_clr)
            acc_reg <= '0;
        else if (cw.acc_en)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    // Round to nearest with ties toward plus infinity, then saturate to the
    // 32-bit Q16.16 range.
    assign acc_rounded = acc_reg + ACC_W'(1 << (FRAC_W - 1));
    assign acc_scaled  = acc_rounded[ACC_W-1:FRAC_W];

    always_comb
    begin
        if (acc_scaled > (ACC_W-FRAC_W)'(signed'({1'b0, {(DATA_W-1){1'b1}}})))
            sat_result = {1'b0, {(DATA_W-1){1'b1}}};
        else if (acc_scaled < (ACC_W-FRAC_W)'(signed'({1'b1, {(DATA_W-1){1'b0}}})))
            sat_result = {1'b1, {(DATA_W-1){1'b0}}};
        else
            sat_result = acc_scaled[DATA_W-1:0];
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    // The emit step is reached only after the wait step has found the
    // register free, so a finished element never overwrites one that still
    // waits for its transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cw.emit)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cw.emit)
        begin
            out_row_reg     <= ROW_W'(i_reg);
            out_col_reg     <= ROW_W'(j_reg);
            out_product_reg <= sat_result;
            out_last_reg    <= !elem_more;
        end
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.out_row = out_row_reg;
    assign out_ch.out_col = out_col_reg;
    assign out_ch.product = out_product_reg;
    assign out_ch.last    = out_last_reg;

`ifndef SYNTHESIS
    // A new element is never loaded over one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cw.emit |-> (!out_valid_reg || out_ch.ready))
        else $error("output register overwritten before its transfer");

    // The inner index never runs past the inner dimension while reading.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_READ) |-> (k_reg <= n_lim))
        else $error("inner index beyond the inner dimension");

    // After the final element of a run the sequencer heads back to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cw.emit && !elem_more) |=> (pc_reg == PC_RETURN))
        else $error("run did not end after its final element");

    // Only a transfer in the idle step starts a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_START) |-> ($past(run_xfer) || ($past(pc_reg) == PC_EMIT)))
        else $error("element started without a run");
`endif

endmodule
